// ===== hdl/bbs_pkg.sv =====
package bbs_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_FETCH,
    ST_RUN,
    ST_TAIL,
    ST_OUT_RD,
    ST_OUT_FETCH,
    ST_OUT_HOLD
  } state_t;

endpackage

// ===== hdl/bbs_ram.sv =====
module bbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/bidirectional_bubble_sorter_core.sv =====
// Cocktail shaker sorter for sets of signed 32-bit values.
// Input stream (s_*): one value per transfer; s_tlast closes the set and
// starts the sort. Up to DEPTH values are kept; later ones, the closing one
// included, are dropped and the whole set is reported with m_tuser high.
// Output stream (m_*): the stored values in ascending order, m_tlast on the
// greatest one. Equal values keep their arrival order.
// Loading accepts one value per cycle. For a set of n >= 2 values the sort
// runs n-1 alternating passes over a shrinking window; each pass is paced
// by the single read port of the store. Each result is then read,
// registered and presented in turn; the next one is read only after the
// receiver takes it.
// s_tready is low from the closing transfer until the last result is taken.
// A stalled receiver holds m_tvalid and the result register unchanged; the
// sorter waits.
// Reset (rst, synchronous) empties the set and returns to loading; the
// store needs no clearing, since only entries of the current set are read.
module bidirectional_bubble_sorter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic signed [bbs_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic signed [bbs_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
  output logic                            m_tlast,
  output logic                            m_tuser     // [0] overflow
);

  bbs_pkg::state_t state, state_next;

  logic [bbs_pkg::CNT_W-1:0]  count;
  logic [bbs_pkg::CNT_W-1:0]  passes;
  logic                       ovf;
  logic                       dir;
  logic [bbs_pkg::ADDR_W-1:0] left;
  logic [bbs_pkg::ADDR_W-1:0] right;
  logic [bbs_pkg::ADDR_W-1:0] idx;
  logic [bbs_pkg::ADDR_W-1:0] oidx;
  logic signed [bbs_pkg::DATA_W-1:0] cur;
  logic signed [bbs_pkg::DATA_W-1:0] out_data;

  logic                       wr_en;
  logic [bbs_pkg::ADDR_W-1:0] wr_addr;
  logic [bbs_pkg::DATA_W-1:0] wr_data;
  logic [bbs_pkg::ADDR_W-1:0] rd_addr;
  logic [bbs_pkg::DATA_W-1:0] rd_data;

  logic                       room;
  logic [bbs_pkg::CNT_W-1:0]  cnt_after;
  logic [bbs_pkg::CNT_W-1:0]  cnt_after_m1;
  logic [bbs_pkg::CNT_W-1:0]  count_m1;
  logic [bbs_pkg::ADDR_W-1:0] nb;
  logic [bbs_pkg::ADDR_W-1:0] nb2;
  logic [bbs_pkg::ADDR_W-1:0] win_end;
  logic signed [bbs_pkg::DATA_W-1:0] d;
  logic                       keep;
  logic                       in_xfer;
  logic                       out_xfer;
  logic                       out_last;

  bbs_ram #(
    .WIDTH(bbs_pkg::DATA_W),
    .DEPTH(bbs_pkg::DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign room         = count < bbs_pkg::CNT_W'(bbs_pkg::DEPTH);
  assign cnt_after    = room ? count + 1'b1 : count;
  assign cnt_after_m1 = cnt_after - 1'b1;
  assign count_m1     = count - 1'b1;
  assign nb           = dir ? idx - 1'b1 : idx + 1'b1;
  assign nb2          = dir ? idx - 2'd2 : idx + 2'd2;
  assign win_end      = dir ? left : right;
  assign d            = $signed(rd_data);
  assign keep         = dir ? (d > cur) : (cur > d);
  assign in_xfer      = s_tvalid && s_tready;
  assign out_xfer     = m_tvalid && m_tready;
  assign out_last     = oidx == count_m1[bbs_pkg::ADDR_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      bbs_pkg::ST_LOAD: begin
        if (s_tvalid && s_tlast) begin
          state_next = (cnt_after >= bbs_pkg::CNT_W'(2)) ? bbs_pkg::ST_PRIME
                                                          : bbs_pkg::ST_OUT_RD;
        end
      end
      bbs_pkg::ST_PRIME:     state_next = bbs_pkg::ST_FETCH;
      bbs_pkg::ST_FETCH:     state_next = bbs_pkg::ST_RUN;
      bbs_pkg::ST_RUN: begin
        if (nb == win_end) begin
          state_next = bbs_pkg::ST_TAIL;
        end
      end
      bbs_pkg::ST_TAIL: begin
        state_next = (passes == bbs_pkg::CNT_W'(1)) ? bbs_pkg::ST_OUT_RD
                                                    : bbs_pkg::ST_PRIME;
      end
      bbs_pkg::ST_OUT_RD:    state_next = bbs_pkg::ST_OUT_FETCH;
      bbs_pkg::ST_OUT_FETCH: state_next = bbs_pkg::ST_OUT_HOLD;
      bbs_pkg::ST_OUT_HOLD: begin
        if (m_tready) begin
          state_next = out_last ? bbs_pkg::ST_LOAD : bbs_pkg::ST_OUT_RD;
        end
      end
      default:               state_next = bbs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_data  = cur;
    rd_addr  = idx;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      bbs_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        wr_en    = s_tvalid && room;
        wr_addr  = count[bbs_pkg::ADDR_W-1:0];
        wr_data  = s_tdata;
      end
      bbs_pkg::ST_PRIME:     rd_addr = dir ? right : left;
      bbs_pkg::ST_FETCH:     rd_addr = nb;
      bbs_pkg::ST_RUN: begin
        wr_en   = 1'b1;
        wr_data = keep ? d : cur;
        rd_addr = nb2;
      end
      bbs_pkg::ST_TAIL:      wr_en = 1'b1;
      bbs_pkg::ST_OUT_RD:    rd_addr = oidx;
      bbs_pkg::ST_OUT_FETCH: rd_addr = oidx;
      bbs_pkg::ST_OUT_HOLD:  m_tvalid = 1'b1;
      default:               s_tready = 1'b0;
    endcase
  end

  assign m_tdata = out_data;
  assign m_tlast = out_last;
  assign m_tuser = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bbs_pkg::ST_LOAD;
      count  <= '0;
      ovf    <= 1'b0;
      dir    <= 1'b0;
      left   <= '0;
      right  <= '0;
      passes <= '0;
      oidx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        bbs_pkg::ST_LOAD: begin
          if (in_xfer) begin
            count <= cnt_after;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              dir    <= 1'b0;
              left   <= '0;
              right  <= cnt_after_m1[bbs_pkg::ADDR_W-1:0];
              passes <= cnt_after_m1;
              oidx   <= '0;
            end
          end
        end
        bbs_pkg::ST_TAIL: begin
          if (dir) begin
            left <= left + 1'b1;
          end else begin
            right <= right - 1'b1;
          end
          dir    <= ~dir;
          passes <= passes - 1'b1;
        end
        bbs_pkg::ST_OUT_HOLD: begin
          if (m_tready) begin
            if (out_last) begin
              count  <= '0;
              ovf    <= 1'b0;
              dir    <= 1'b0;
              left   <= '0;
              right  <= '0;
              passes <= '0;
              oidx   <= '0;
            end else begin
              oidx <= oidx + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bbs_pkg::ST_PRIME:     idx <= dir ? right : left;
      bbs_pkg::ST_FETCH:     cur <= d;
      bbs_pkg::ST_RUN: begin
        idx <= nb;
        if (!keep) begin
          cur <= d;
        end
      end
      bbs_pkg::ST_OUT_FETCH: out_data <= d;
      default: begin
      end
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output open together");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bbs_pkg::CNT_W'(bbs_pkg::DEPTH))
    else $error("element count beyond store depth");

  a_run_passes: assert property (@(posedge clk) disable iff (rst)
    (state == bbs_pkg::ST_RUN || state == bbs_pkg::ST_TAIL) |-> passes != '0)
    else $error("pass running with no passes left");

  a_set_closed: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast) |=> (count == '0 && !ovf && s_tready))
    else $error("set not cleared after final result");

endmodule
